### design/fdg_pkg.sv
`timescale 1ns / 1ps
// Package for the IPv4 fragment descriptor generator: request and result types,
// configuration struct, status and register codes. No dependencies.
package fdg_pkg;

    // Action carried with each input request
    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_ADVANCE = 1'b1
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LOAD_OK  = 2'd0,
        ST_LOAD_REJ = 2'd1,
        ST_DESC     = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_FRAG_SIZE     = 2'd0,
        REG_KEEP_L4_HDR   = 2'd1,
        REG_MIN_LAST_FRAG = 2'd2,
        REG_OVERLAP_MODE  = 2'd3
    } t_reg_idx;

    localparam logic [15:0] FRAG_SIZE_RST = 16'd8;
    localparam logic [15:0] MF_BIT        = 16'h2000;

    // Protocol numbers that set the transport header length
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Fixed transport header length for UDP, ICMP and IGMP
    localparam logic [16:0] SHORT_XPORT_LEN = 17'd8;

    typedef struct packed {
        logic [15:0] frag_size;
        logic        keep_l4_hdr;
        logic [2:0]  min_last_frag;
        logic        overlap_mode;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [15:0] captured_length;
        logic [7:0]  protocol;
        logic [3:0]  tcp_offset_words;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] frag_length;
        logic [15:0] payload_start;
        logic [15:0] payload_length;
        logic [15:0] offset_word;
        logic        zero_fill;
        logic        last;
    } t_result;

endpackage

### design/ipv4_fragment_descriptor_gen_unit.sv
`timescale 1ns / 1ps
// IPv4 fragment descriptor generator, top level: input register, descriptor
// engine, result register. One result per request, registered first in the input register
// and then in the result register; one request accepted per cycle while results are taken.
// Synchronous active-low reset clears the packet state, both stage valids and
// the configuration (frag_size 8, all other registers 0).
// Depends on fdg_pkg, fdg_cfg_regs and fdg_engine.
module ipv4_fragment_descriptor_gen_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // header_words, total_length, captured_length,
                                       // protocol, tcp_offset_words
    input  logic        s_axis_tuser,  // action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // frag_length, payload_start, payload_length,
                                       // offset_word
    output logic [2:0]  m_axis_tuser,  // status[1:0], zero_fill
    output logic        m_axis_tlast   // last
);

    fdg_pkg::t_cfg     w_cfg;
    fdg_pkg::t_in_item r_in_item;
    logic              r_in_valid;
    fdg_pkg::t_result  w_result;
    fdg_pkg::t_result  r_out;
    logic              r_out_valid;
    logic              w_step;
    logic              w_in_fire;

    fdg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // A request moves into the result register when that slot is free
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    fdg_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .i_step   (w_step),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_item.action           <= fdg_pkg::t_action'(s_axis_tuser);
            r_in_item.header_words     <= s_axis_tdata[3:0];
            r_in_item.total_length     <= s_axis_tdata[19:4];
            r_in_item.captured_length  <= s_axis_tdata[35:20];
            r_in_item.protocol         <= s_axis_tdata[43:36];
            r_in_item.tcp_offset_words <= s_axis_tdata[47:44];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.offset_word, r_out.payload_length,
                            r_out.payload_start, r_out.frag_length};
    assign m_axis_tuser  = {r_out.zero_fill, r_out.status};
    assign m_axis_tlast  = r_out.last;

endmodule

### design/fdg_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the fragment descriptor generator.
// Depends on fdg_pkg for the register indexes and the t_cfg struct.
module fdg_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fdg_pkg::t_cfg     o_cfg
);

    fdg_pkg::t_cfg    r_cfg;
    fdg_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = fdg_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frag_size     <= fdg_pkg::FRAG_SIZE_RST;
            r_cfg.keep_l4_hdr   <= 1'b0;
            r_cfg.min_last_frag <= 3'd0;
            r_cfg.overlap_mode  <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                fdg_pkg::REG_FRAG_SIZE:     r_cfg.frag_size     <= pwdata[15:0];
                fdg_pkg::REG_KEEP_L4_HDR:   r_cfg.keep_l4_hdr   <= pwdata[0];
                fdg_pkg::REG_MIN_LAST_FRAG: r_cfg.min_last_frag <= pwdata[2:0];
                fdg_pkg::REG_OVERLAP_MODE:  r_cfg.overlap_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        prdata = 32'd0;
        unique case (w_idx)
            fdg_pkg::REG_FRAG_SIZE:     prdata = {16'd0, r_cfg.frag_size};
            fdg_pkg::REG_KEEP_L4_HDR:   prdata = {31'd0, r_cfg.keep_l4_hdr};
            fdg_pkg::REG_MIN_LAST_FRAG: prdata = {29'd0, r_cfg.min_last_frag};
            fdg_pkg::REG_OVERLAP_MODE:  prdata = {31'd0, r_cfg.overlap_mode};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

### design/fdg_engine.sv
`timescale 1ns / 1ps
// Packet state and single-pass descriptor logic: one request in, one result out.
// Depends on fdg_pkg for request, result and configuration types.
module fdg_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdg_pkg::t_cfg     i_cfg,
    input  fdg_pkg::t_in_item i_item,
    input  logic              i_step,
    output fdg_pkg::t_result  o_result
);

    // Packet state
    logic        r_active,      n_active;
    logic [5:0]  r_hdr_bytes,   n_hdr_bytes;
    logic [15:0] r_payload_end, n_payload_end;
    logic [16:0] r_position,    n_position;
    logic [16:0] r_next_length, n_next_length;
    logic        r_null_pending, n_null_pending;

    // Load path
    logic [5:0]  w_hdr;
    logic [16:0] w_first_raw;
    logic [16:0] w_first_len;
    logic [16:0] w_need;
    logic        w_load_ok;

    // Advance path
    logic [17:0] w_end_pos;
    logic        w_is_last;
    logic [15:0] w_offw;
    logic [15:0] w_half;
    logic [12:0] w_units;
    logic [16:0] w_limit;
    logic [16:0] w_rem;
    logic        w_overlap;

    // First fragment length, before rounding
    always_comb begin
        w_first_raw = {1'b0, i_cfg.frag_size};
        if (i_cfg.keep_l4_hdr) begin
            case (i_item.protocol) inside
                fdg_pkg::PROTO_TCP:
                    w_first_raw = {11'd0, i_item.tcp_offset_words, 2'b00};
                fdg_pkg::PROTO_UDP, fdg_pkg::PROTO_ICMP, fdg_pkg::PROTO_IGMP:
                    w_first_raw = fdg_pkg::SHORT_XPORT_LEN;
                default:
                    w_first_raw = {1'b0, i_cfg.frag_size};
            endcase
        end
    end

    // Round up to 8 and check the load
    assign w_hdr       = {i_item.header_words, 2'b00};
    assign w_first_len = (w_first_raw[2:0] != 3'd0)
                       ? {w_first_raw[16:3] + 14'd1, 3'b000} : w_first_raw;
    assign w_need      = {11'd0, w_hdr} + w_first_len + {14'd0, i_cfg.min_last_frag};
    assign w_load_ok   = (i_cfg.frag_size != 16'd0) && (i_cfg.frag_size[2:0] == 3'd0)
                       && ({1'b0, i_item.captured_length} > w_need)
                       && (i_item.total_length > {10'd0, w_hdr});

    // Advance arithmetic on the current fragment
    assign w_end_pos = {1'b0, r_position} + {1'b0, r_next_length};
    assign w_is_last = w_end_pos >= {2'b00, r_payload_end};
    assign w_offw    = (w_is_last ? 16'h0000 : fdg_pkg::MF_BIT) | {2'b00, r_position[16:3]};
    assign w_half    = r_next_length[16:1];
    assign w_units   = w_half[15:3];
    assign w_limit   = {1'b0, i_cfg.frag_size} + {14'd0, i_cfg.min_last_frag};
    assign w_rem     = {1'b0, r_payload_end} - w_end_pos[16:0];
    assign w_overlap = i_cfg.overlap_mode && !w_is_last && !r_null_pending;

    // Result and next state
    always_comb begin
        n_active       = r_active;
        n_hdr_bytes    = r_hdr_bytes;
        n_payload_end  = r_payload_end;
        n_position     = r_position;
        n_next_length  = r_next_length;
        n_null_pending = r_null_pending;
        o_result       = '0;
        o_result.status = fdg_pkg::ST_IDLE;

        if (i_item.action == fdg_pkg::ACT_LOAD) begin
            if (w_load_ok) begin
                o_result.status = fdg_pkg::ST_LOAD_OK;
                n_active       = 1'b1;
                n_hdr_bytes    = w_hdr;
                n_payload_end  = i_item.total_length - {10'd0, w_hdr};
                n_position     = 17'd0;
                n_next_length  = w_first_len;
                n_null_pending = 1'b0;
            end else begin
                o_result.status = fdg_pkg::ST_LOAD_REJ;
                n_active       = 1'b0;
                n_null_pending = 1'b0;
            end
        end else if (r_active) begin
            o_result.status = fdg_pkg::ST_DESC;
            if (w_overlap) begin
                // zero-filled half fragment over the back half of the next one
                o_result.frag_length    = {10'd0, r_hdr_bytes} + w_half;
                o_result.payload_start  = r_position[15:0] + {w_units, 3'b000};
                o_result.payload_length = w_half;
                o_result.offset_word    = w_offw + {3'd0, w_units};
                o_result.zero_fill      = 1'b1;
                n_null_pending          = 1'b1;
            end else begin
                o_result.frag_length    = {10'd0, r_hdr_bytes} + r_next_length[15:0];
                o_result.payload_start  = r_position[15:0];
                o_result.payload_length = r_next_length[15:0];
                o_result.offset_word    = w_offw;
                o_result.last           = w_is_last;
                n_null_pending          = 1'b0;
                n_position              = w_end_pos[16:0];
                if (w_is_last) begin
                    n_active      = 1'b0;
                    n_next_length = 17'd0;
                end else begin
                    n_next_length = (w_rem > w_limit) ? {1'b0, i_cfg.frag_size} : w_rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_hdr_bytes    <= 6'd0;
            r_payload_end  <= 16'd0;
            r_position     <= 17'd0;
            r_next_length  <= 17'd0;
            r_null_pending <= 1'b0;
        end else if (i_step) begin
            r_active       <= n_active;
            r_hdr_bytes    <= n_hdr_bytes;
            r_payload_end  <= n_payload_end;
            r_position     <= n_position;
            r_next_length  <= n_next_length;
            r_null_pending <= n_null_pending;
        end
    end

endmodule
